@@ rtl/qdec_pkg.sv @@
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared widths, register codes and types of the dual quadrature decoder.
// ----------------------------------------------------------------------------
package qdec_pkg;

    // result count field width and default internal count width
    localparam int OUT_COUNT_W     = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_LEFT_REVERSE  = 1'b0;
    localparam logic REG_RIGHT_REVERSE = 1'b1;

    // register reset values
    localparam logic LEFT_REVERSE_RST  = 1'b0;
    localparam logic RIGHT_REVERSE_RST = 1'b1;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // per-channel decode flags
    typedef struct packed {
        logic dir;
        logic dbl;
    } chan_flags_t;

    // configuration handed from the register block to the datapath
    typedef struct packed {
        logic left_reverse;
        logic right_reverse;
    } qdec_cfg_t;

endpackage

@@ rtl/qdec_if.sv @@
// ----------------------------------------------------------------------------
// qdec_if
// Valid/ready channels for pin samples and decoded results.
// ----------------------------------------------------------------------------
interface qdec_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;

    modport source (
        output valid, kind, left_a, left_b, right_a, right_b,
        input  ready
    );
    modport sink (
        input  valid, kind, left_a, left_b, right_a, right_b,
        output ready
    );
endinterface

interface qdec_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic               left_direction;
    logic               right_direction;
    logic               left_double_change;
    logic               right_double_change;

    modport source (
        output valid, left_count, right_count, left_direction, right_direction,
               left_double_change, right_double_change,
        input  ready
    );
    modport sink (
        input  valid, left_count, right_count, left_direction, right_direction,
               left_double_change, right_double_change,
        output ready
    );
endinterface

@@ rtl/dual_quadrature_decoder.sv @@
// ----------------------------------------------------------------------------
// dual_quadrature_decoder
// Decodes a left and a right quadrature encoder at four counts per encoder cycle.
//
// Usage: each beat on in_ch is either a pin sample (kind 0) with the four
// phase levels, or a clear (kind 1) that zeroes both counts. Every beat
// produces exactly one beat on out_ch with both counts, the last decoded
// directions and the double-change flags of that sample.
// An input beat passes the input register, then is decoded into the result
// register. Throughput is one beat per cycle while out_ch does not stall;
// the count update of one sample is a single step up or down per channel, or none.
// When out_ch stalls, the result register holds and the input register
// still takes one more beat; in_ch.ready then drops until the result moves.
// Reset clears both counts, sets both directions forward, clears the
// primed flag so the first sample only records the pin levels, and loads
// the reverse registers (left 0, right 1). The APB port sets the reverse
// bits at byte addresses 0 (left) and 4 (right), always ready.
// ----------------------------------------------------------------------------
module dual_quadrature_decoder #(
    parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    qdec_in_if.sink                         in_ch,
    qdec_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qdec_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qdec_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qdec_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import qdec_pkg::*;

    qdec_cfg_t cfg;

    // input register
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [3:0] in_pins_reg;

    // decoder state
    logic [3:0]             prev_pins_reg;
    logic                   primed_reg;
    logic [COUNT_WIDTH-1:0] left_pos_reg;
    logic [COUNT_WIDTH-1:0] right_pos_reg;
    logic                   left_dir_reg;
    logic                   right_dir_reg;

    // result register
    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_left_reg;
    logic [COUNT_WIDTH-1:0] out_right_reg;
    logic                   out_left_dir_reg;
    logic                   out_right_dir_reg;
    logic                   out_left_dbl_reg;
    logic                   out_right_dbl_reg;

    logic [COUNT_WIDTH-1:0] left_pos_next;
    logic [COUNT_WIDTH-1:0] right_pos_next;
    logic [COUNT_WIDTH-1:0] left_step_cnt;
    logic [COUNT_WIDTH-1:0] right_step_cnt;
    logic                   left_dir_next;
    logic                   right_dir_next;
    logic                   left_dbl_next;
    logic                   right_dbl_next;
    chan_flags_t            left_flags;
    chan_flags_t            right_flags;

    logic advance;
    logic in_accept;
    logic is_clear;

    qdec_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline handshake
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign is_clear    = (in_kind_reg == KIND_CLEAR);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg <= in_ch.kind;
            in_pins_reg <= {in_ch.right_b, in_ch.right_a, in_ch.left_b, in_ch.left_a};
        end
    end

    // per-channel decode
    qdec_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
        .primed     (primed_reg),
        .a          (in_pins_reg[0]),
        .b          (in_pins_reg[1]),
        .prev_a     (prev_pins_reg[0]),
        .prev_b     (prev_pins_reg[1]),
        .reverse    (cfg.left_reverse),
        .count      (left_pos_reg),
        .dir        (left_dir_reg),
        .count_next (left_step_cnt),
        .flags      (left_flags)
    );

    qdec_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
        .primed     (primed_reg),
        .a          (in_pins_reg[2]),
        .b          (in_pins_reg[3]),
        .prev_a     (prev_pins_reg[2]),
        .prev_b     (prev_pins_reg[3]),
        .reverse    (cfg.right_reverse),
        .count      (right_pos_reg),
        .dir        (right_dir_reg),
        .count_next (right_step_cnt),
        .flags      (right_flags)
    );

    // clear item zeroes counts and keeps directions and pin history
    always_comb
    begin
        if (is_clear)
        begin
            left_pos_next  = '0;
            right_pos_next = '0;
            left_dir_next  = left_dir_reg;
            right_dir_next = right_dir_reg;
            left_dbl_next  = 1'b0;
            right_dbl_next = 1'b0;
        end
        else
        begin
            left_pos_next  = left_step_cnt;
            right_pos_next = right_step_cnt;
            left_dir_next  = left_flags.dir;
            right_dir_next = right_flags.dir;
            left_dbl_next  = left_flags.dbl;
            right_dbl_next = right_flags.dbl;
        end
    end

    // decoder state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= '0;
            primed_reg    <= 1'b0;
            left_pos_reg  <= '0;
            right_pos_reg <= '0;
            left_dir_reg  <= 1'b1;
            right_dir_reg <= 1'b1;
        end
        else if (advance)
        begin
            left_pos_reg  <= left_pos_next;
            right_pos_reg <= right_pos_next;
            left_dir_reg  <= left_dir_next;
            right_dir_reg <= right_dir_next;
            if (!is_clear)
            begin
                prev_pins_reg <= in_pins_reg;
                primed_reg    <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_left_reg      <= left_pos_next;
            out_right_reg     <= right_pos_next;
            out_left_dir_reg  <= left_dir_next;
            out_right_dir_reg <= right_dir_next;
            out_left_dbl_reg  <= left_dbl_next;
            out_right_dbl_reg <= right_dbl_next;
        end
    end

    // result beat, counts carry their low bits, or are zero-extended when narrower
    assign out_ch.valid               = out_valid_reg;
    assign out_ch.left_direction      = out_left_dir_reg;
    assign out_ch.right_direction     = out_right_dir_reg;
    assign out_ch.left_double_change  = out_left_dbl_reg;
    assign out_ch.right_double_change = out_right_dbl_reg;

    generate
        if (COUNT_WIDTH >= OUT_COUNT_W)
        begin : g_trunc
            assign out_ch.left_count  = out_left_reg[OUT_COUNT_W-1:0];
            assign out_ch.right_count = out_right_reg[OUT_COUNT_W-1:0];
        end
        else
        begin : g_zext
            assign out_ch.left_count  = {{(OUT_COUNT_W-COUNT_WIDTH){1'b0}}, out_left_reg};
            assign out_ch.right_count = {{(OUT_COUNT_W-COUNT_WIDTH){1'b0}}, out_right_reg};
        end
    endgenerate

endmodule

@@ rtl/qdec_apb_regs.sv @@
// ----------------------------------------------------------------------------
// qdec_apb_regs
// APB register block holding the left and right reverse bits.
// ----------------------------------------------------------------------------
module qdec_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qdec_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qdec_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qdec_pkg::APB_DATA_W-1:0] prdata,
    output logic                         pready,
    output qdec_pkg::qdec_cfg_t          cfg
);
    import qdec_pkg::*;

    logic left_reverse_reg;
    logic right_reverse_reg;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reverse_reg  <= LEFT_REVERSE_RST;
            right_reverse_reg <= RIGHT_REVERSE_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_LEFT_REVERSE:  left_reverse_reg  <= pwdata[0];
                REG_RIGHT_REVERSE: right_reverse_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            REG_LEFT_REVERSE:  prdata[0] = left_reverse_reg;
            REG_RIGHT_REVERSE: prdata[0] = right_reverse_reg;
            default:           prdata    = '0;
        endcase
    end

    assign cfg.left_reverse  = left_reverse_reg;
    assign cfg.right_reverse = right_reverse_reg;

endmodule

@@ rtl/qdec_channel.sv @@
// ----------------------------------------------------------------------------
// qdec_channel
// Single-channel x4 quadrature step decode: next count, direction and
// double-change flag from the current and previous phase levels.
// ----------------------------------------------------------------------------
module qdec_channel #(
    parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                    primed,
    input  logic                    a,
    input  logic                    b,
    input  logic                    prev_a,
    input  logic                    prev_b,
    input  logic                    reverse,
    input  logic [COUNT_WIDTH-1:0]  count,
    input  logic                    dir,
    output logic [COUNT_WIDTH-1:0]  count_next,
    output qdec_pkg::chan_flags_t   flags
);
    import qdec_pkg::*;

    logic da;
    logic db;
    logic step;
    logic fwd;

    // edge detect against the previous sample
    assign da   = a ^ prev_a;
    assign db   = b ^ prev_b;
    assign step = primed && (da ^ db);

    // A edge: equal phases is forward; B edge: unequal phases is forward
    assign fwd = da ? (a == b) : (a != b);

    // count up or down, reverse flips the sense
    always_comb
    begin
        count_next = count;
        if (step)
        begin
            if (fwd ^ reverse)
                count_next = count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            else
                count_next = count - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    assign flags.dir = step ? fwd : dir;
    assign flags.dbl = primed && da && db;

endmodule

@@ tb/dual_quadrature_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_quadrature_decoder_tb
// Drives pin samples and clears into the decoder with random gaps on both
// channels. A predictor in the testbench tracks the pin history, the counts
// and the directions under each reverse setting, and every result beat is
// checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module dual_quadrature_decoder_tb;
    import qdec_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        logic signed [OUT_COUNT_W-1:0] left_count;
        logic signed [OUT_COUNT_W-1:0] right_count;
        logic                          left_direction;
        logic                          right_direction;
        logic                          left_double_change;
        logic                          right_double_change;
    } decode_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    qdec_in_if  in_bus ();
    qdec_out_if out_bus ();

    dual_quadrature_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted decoder state, pins kept as {a, b}
    logic [1:0]  prev_left;
    logic [1:0]  prev_right;
    logic        primed;
    logic [31:0] left_pos;
    logic [31:0] right_pos;
    logic        left_dir;
    logic        right_dir;
    logic        left_rev;
    logic        right_rev;

    decode_result_t expected_results[$];

    int unsigned cycle_count    = 0;
    int unsigned fail_count     = 0;
    int          tx_gap_pct     = 0;
    int          rx_gap_pct     = 0;
    int          rx_hold_cycles = 0;

    // current encoder levels {a, b} used by the stimulus walkers
    logic [1:0] left_pins;
    logic [1:0] right_pins;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("dual_quadrature_decoder: mismatch");
            $finish;
        end
    end

    // gap length, mostly short with a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return $urandom_range(3, 1);
        else if (roll < 95)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // one quadrature step of a channel, returns the double-change flag
    function automatic logic step_channel(input logic [1:0] pins, input logic [1:0] prev,
                                          input logic reverse, inout logic [31:0] pos,
                                          inout logic dir);
        logic a_moved;
        logic b_moved;
        logic fwd;
        a_moved = pins[1] ^ prev[1];
        b_moved = pins[0] ^ prev[0];
        if (a_moved && b_moved)
            return 1'b1;
        if (!a_moved && !b_moved)
            return 1'b0;
        fwd = a_moved ? (pins[1] == pins[0]) : (pins[1] != pins[0]);
        dir = fwd;
        if (fwd ^ reverse)
            pos = pos + 32'd1;
        else
            pos = pos - 32'd1;
        return 1'b0;
    endfunction

    // expected result of one accepted beat, advancing the predicted state
    function automatic decode_result_t predict_result(input logic kind, input logic [1:0] lp,
                                                      input logic [1:0] rp);
        decode_result_t res;
        logic           ldbl;
        logic           rdbl;
        ldbl = 1'b0;
        rdbl = 1'b0;
        if (kind == KIND_CLEAR)
        begin
            left_pos  = '0;
            right_pos = '0;
        end
        else
        begin
            // first sample after reset only records the levels
            if (primed)
            begin
                ldbl = step_channel(lp, prev_left, left_rev, left_pos, left_dir);
                rdbl = step_channel(rp, prev_right, right_rev, right_pos, right_dir);
            end
            prev_left  = lp;
            prev_right = rp;
            primed     = 1'b1;
        end
        res.left_count          = left_pos;
        res.right_count         = right_pos;
        res.left_direction      = left_dir;
        res.right_direction     = right_dir;
        res.left_double_change  = ldbl;
        res.right_double_change = rdbl;
        return res;
    endfunction

    // next levels for one step in the given direction
    function automatic logic [1:0] walk_pins(input logic [1:0] ab, input logic forward);
        if ((ab[1] == ab[0]) == forward)
            return ab ^ 2'b01;
        return ab ^ 2'b10;
    endfunction

    // random channel motion: mostly single steps, some double changes and holds
    function automatic logic [1:0] random_move(input logic [1:0] ab);
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return walk_pins(ab, 1'b1);
        else if (roll < 70)
            return walk_pins(ab, 1'b0);
        else if (roll < 80)
            return ab ^ 2'b11;
        else if (roll < 95)
            return ab;
        return 2'($urandom);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            if (fail_count < MAX_REPORTS)
                $display("%0t %s expected 0x%08h actual 0x%08h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // send one beat; called at a rising edge and returns at one
    task automatic send_beat(input logic kind, input logic [1:0] lp, input logic [1:0] rp);
        int gap;
        in_bus.valid   <= 1'b1;
        in_bus.kind    <= kind;
        in_bus.left_a  <= lp[1];
        in_bus.left_b  <= lp[0];
        in_bus.right_a <= rp[1];
        in_bus.right_b <= rp[0];
        do
            @(negedge clk);
        while (in_bus.ready !== 1'b1);
        @(posedge clk);
        expected_results.push_back(predict_result(kind, lp, rp));
        gap = ($urandom_range(99) < tx_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_walkers();
        send_beat(KIND_SAMPLE, left_pins, right_pins);
    endtask

    // stop sending and let every expected beat arrive
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write, setup then access phase
    task automatic write_reg(input logic idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= {31'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (pready !== 1'b1);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LEFT_REVERSE)
            left_rev = value;
        else
            right_rev = value;
    endtask

    // wait for idle, then write both reverse bits with the bus idle between the writes
    task automatic set_reverse(input logic lrev, input logic rrev);
        wait_idle();
        write_reg(REG_LEFT_REVERSE, lrev);
        @(posedge clk);
        write_reg(REG_RIGHT_REVERSE, rrev);
    endtask

    // reset values, priming, full cycles both ways, holds, double changes, clears
    task automatic test_directed();
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        // clear before the first sample leaves the block unprimed
        send_beat(KIND_CLEAR, 2'b11, 2'b11);
        left_pins  = 2'b11;
        right_pins = 2'b11;
        send_walkers();
        // left forward, right backward over a full cycle
        for (int i = 0; i < 4; i++)
        begin
            left_pins  = walk_pins(left_pins, 1'b1);
            right_pins = walk_pins(right_pins, 1'b0);
            send_walkers();
        end
        // and the other way round
        for (int i = 0; i < 4; i++)
        begin
            left_pins  = walk_pins(left_pins, 1'b0);
            right_pins = walk_pins(right_pins, 1'b1);
            send_walkers();
        end
        // no change on either side
        send_walkers();
        // both phases change on both channels
        left_pins  = left_pins ^ 2'b11;
        right_pins = right_pins ^ 2'b11;
        send_walkers();
        // double change on the left while the right steps
        left_pins  = left_pins ^ 2'b11;
        right_pins = walk_pins(right_pins, 1'b1);
        send_walkers();
        // clear ignores its pins and keeps the previous levels
        send_beat(KIND_CLEAR, ~left_pins, ~right_pins);
        send_walkers();
        // counts go below zero
        for (int i = 0; i < 3; i++)
        begin
            left_pins  = walk_pins(left_pins, 1'b0);
            right_pins = walk_pins(right_pins, 1'b1);
            send_walkers();
        end
    endtask

    // every reverse combination with runs in both directions
    task automatic test_reverse_settings();
        logic [1:0] setting;
        tx_gap_pct = 20;
        rx_gap_pct = 20;
        for (int s = 0; s < 4; s++)
        begin
            setting = 2'(s);
            set_reverse(setting[0], setting[1]);
            for (int i = 0; i < 40; i++)
            begin
                left_pins  = walk_pins(left_pins, i < 20);
                right_pins = walk_pins(right_pins, i >= 20);
                send_walkers();
            end
        end
    endtask

    // long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure();
        wait_idle();
        tx_gap_pct     = 0;
        rx_gap_pct     = 0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 40; i++)
        begin
            left_pins  = random_move(left_pins);
            right_pins = random_move(right_pins);
            send_walkers();
        end
        wait_idle();
    endtask

    // random walks under random settings, with clears and noise beats
    task automatic test_random();
        int         roll;
        logic       kind;
        logic [1:0] lp;
        logic [1:0] rp;
        for (int phase = 0; phase < 8; phase++)
        begin
            set_reverse(1'($urandom), 1'($urandom));
            tx_gap_pct = (phase % 3 == 0) ? 0 : 30;
            rx_gap_pct = (phase % 3 == 0) ? 0 : 30;
            for (int i = 0; i < 215; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                begin
                    send_beat(KIND_CLEAR, 2'($urandom), 2'($urandom));
                end
                else if (roll < 6)
                begin
                    kind = 1'($urandom);
                    lp   = 2'($urandom);
                    rp   = 2'($urandom);
                    if (kind == KIND_SAMPLE)
                    begin
                        left_pins  = lp;
                        right_pins = rp;
                    end
                    send_beat(kind, lp, rp);
                end
                else
                begin
                    left_pins  = random_move(left_pins);
                    right_pins = random_move(right_pins);
                    send_walkers();
                end
            end
        end
    endtask

    // result receiver, random stalls plus the requested hold-off
    initial
    begin : receiver
        int gap_left;
        gap_left = 0;
        out_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_bus.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (gap_left > 0)
            begin
                out_bus.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_bus.ready <= 1'b1;
                if ($urandom_range(99) < rx_gap_pct)
                    gap_left = pick_gap();
            end
        end
    end

    // result checker, a beat seen at the falling edge moves at the next rising edge
    initial
    begin : result_checker
        decode_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t result beat with none expected", $time);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("left_count", want.left_count, out_bus.left_count);
                    check_field("right_count", want.right_count, out_bus.right_count);
                    check_field("left_direction", 32'(want.left_direction),
                                32'(out_bus.left_direction));
                    check_field("right_direction", 32'(want.right_direction),
                                32'(out_bus.right_direction));
                    check_field("left_double_change", 32'(want.left_double_change),
                                32'(out_bus.left_double_change));
                    check_field("right_double_change", 32'(want.right_double_change),
                                32'(out_bus.right_double_change));
                end
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_bus.valid   <= 1'b0;
        in_bus.kind    <= KIND_SAMPLE;
        in_bus.left_a  <= 1'b0;
        in_bus.left_b  <= 1'b0;
        in_bus.right_a <= 1'b0;
        in_bus.right_b <= 1'b0;
        prev_left      = 2'b00;
        prev_right     = 2'b00;
        primed         = 1'b0;
        left_pos       = '0;
        right_pos      = '0;
        left_dir       = 1'b1;
        right_dir      = 1'b1;
        left_rev       = LEFT_REVERSE_RST;
        right_rev      = RIGHT_REVERSE_RST;
        left_pins      = 2'b00;
        right_pins     = 2'b00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_reverse_settings();
        test_backpressure();
        test_random();
        wait_idle();
        if (fail_count == 0)
            $display("dual_quadrature_decoder: match");
        else
            $display("dual_quadrature_decoder: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/qdec_pkg.sv
rtl/qdec_if.sv
rtl/qdec_apb_regs.sv
rtl/qdec_channel.sv
rtl/dual_quadrature_decoder.sv
tb/dual_quadrature_decoder_tb.sv
